// ===== rtl/tsr_pkg.sv =====
// Shared types and constants of the text scrollback ring writer.
package tsr_pkg;

    localparam int ROWS   = 64;
    localparam int COLS   = 80;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ADDR_W = $clog2(ROWS * COLS);

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int RD_ROW_W  = 6;
    localparam int RD_COL_W  = 7;
    localparam int CUR_ROW_W = 6;
    localparam int CUR_COL_W = 7;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             filled;
    } cursor_t;

    typedef struct packed {
        logic              len_we;
        logic [ROW_W-1:0]  len_row;
        logic [COL_W-1:0]  len_val;
        logic              inval_en;
        logic [ROW_W-1:0]  inval_row;
        logic              text_we;
        logic [ADDR_W-1:0] text_addr;
        logic [CHAR_W-1:0] text_data;
    } cur_ops_t;

endpackage

// ===== rtl/tsr_ifs.sv =====
// Request and response channel interfaces of the text scrollback ring writer.
interface tsr_req_if
    import tsr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [CHAR_W-1:0]   ch;
    logic [RD_ROW_W-1:0] read_row;
    logic [RD_COL_W-1:0] read_col;

    modport source (output valid, command, ch, read_row, read_col, input ready);
    modport sink   (input valid, command, ch, read_row, read_col, output ready);
endinterface

interface tsr_rsp_if
    import tsr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    read_char;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic                 filled;

    modport source (output valid, read_char, cursor_row, cursor_col, filled, input ready);
    modport sink   (input valid, read_char, cursor_row, cursor_col, filled, output ready);
endinterface

// ===== rtl/text_scrollback_ring_writer.sv =====
// Top level of the text scrollback ring writer.
// Each request transfer gives exactly one response transfer, through the s1 stage and the
// output register. One request is taken every cycle while the response side is not
// stalled, so the sustained rate is one item per cycle. A put writes the text store and, on
// a row change, the row length memory in the cycle of its transfer; a read looks up both
// memories in that cycle and forms the byte as it leaves the s1 stage. Per-row valid flags
// let a clear drop all row lengths at once, with no clearing pass after reset. Cells never
// written read as zero, since a read at or past the row length returns zero.
module text_scrollback_ring_writer
    import tsr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    tsr_req_if.sink   req,
    tsr_rsp_if.source rsp
);

    cursor_t          cur;
    cur_ops_t         ops;
    logic             req_acc;
    logic             put_en;
    logic             clr_en;
    logic             rd_en;
    logic             rd_ok;
    logic             s1_adv;
    logic [ROWS-1:0]  len_vld_reg;
    logic [COL_W-1:0] len_rdata;
    logic [CHAR_W-1:0] text_rdata;
    logic [COL_W-1:0] row_len;
    logic             hit;

    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic                s1_ok_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [RD_COL_W-1:0] s1_col_reg;

    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    read_char_reg;
    logic [CUR_ROW_W-1:0] cursor_row_reg;
    logic [CUR_COL_W-1:0] cursor_col_reg;
    logic                 filled_reg;

    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_acc   = req.valid && req.ready;
    assign put_en    = req_acc && (cmd_t'(req.command) == CMD_PUT);
    assign clr_en    = req_acc && (cmd_t'(req.command) == CMD_CLEAR);
    assign rd_ok     = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLS);
    assign rd_en     = req_acc && (cmd_t'(req.command) == CMD_READ) && rd_ok;

    tsr_cursor u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .put_en (put_en),
        .clr_en (clr_en),
        .ch     (req.ch),
        .cur    (cur),
        .ops    (ops)
    );

    tsr_ram #(
        .DEPTH (ROWS),
        .WIDTH (COL_W)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (ops.len_we),
        .wr_addr (ops.len_row),
        .wr_data (ops.len_val),
        .rd_en   (rd_en),
        .rd_addr (ROW_W'(req.read_row)),
        .rd_data (len_rdata)
    );

    tsr_ram #(
        .DEPTH (ROWS * COLS),
        .WIDTH (CHAR_W)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (ops.text_we),
        .wr_addr (ops.text_addr),
        .wr_data (ops.text_data),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(32'(req.read_row) * COLS + 32'(req.read_col))),
        .rd_data (text_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg <= '0;
        end
        else if (clr_en)
        begin
            len_vld_reg <= '0;
        end
        else
        begin
            if (ops.len_we)
            begin
                len_vld_reg[ops.len_row] <= 1'b1;
            end
            if (ops.inval_en)
            begin
                len_vld_reg[ops.inval_row] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_cmd_reg <= cmd_t'(req.command);
            s1_ok_reg  <= rd_ok;
            s1_row_reg <= ROW_W'(req.read_row);
            s1_col_reg <= req.read_col;
        end
    end

    always_comb
    begin
        if (s1_row_reg == cur.row)
        begin
            row_len = cur.col;
        end
        else if (len_vld_reg[s1_row_reg])
        begin
            row_len = len_rdata;
        end
        else
        begin
            row_len = '0;
        end
    end

    assign hit = (s1_cmd_reg == CMD_READ) && s1_ok_reg && (32'(s1_col_reg) < 32'(row_len));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            read_char_reg  <= hit ? text_rdata : '0;
            cursor_row_reg <= CUR_ROW_W'(cur.row);
            cursor_col_reg <= CUR_COL_W'(cur.col);
            filled_reg     <= cur.filled;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_char  = read_char_reg;
    assign rsp.cursor_row = cursor_row_reg;
    assign rsp.cursor_col = cursor_col_reg;
    assign rsp.filled     = filled_reg;

    // The cursor column never runs past the row width.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur.col) <= COLS)
        else $error("cursor column beyond row width");

    // A clear transfer leaves the cursor at the origin with the flag low.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_en |=> (cur.row == '0) && (cur.col == '0) && !cur.filled)
        else $error("clear did not reset the cursor");

    // A lookup and a store write never share a cycle.
    a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && (ops.text_we || ops.len_we)))
        else $error("read overlaps a store write");

    // The current row is never marked as holding a stored length.
    a_cur_row_vld: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ops.inval_en) && !$past(clr_en) |-> !len_vld_reg[cur.row])
        else $error("current row marked valid after a row change");

endmodule

// ===== rtl/tsr_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module tsr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tsr_cursor.sv =====
// Cursor state and decoding of put bytes into row and text store writes.
module tsr_cursor
    import tsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              put_en,
    input  logic              clr_en,
    input  logic [CHAR_W-1:0] ch,
    output cursor_t           cur,
    output cur_ops_t          ops
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             filled_reg, filled_next;
    logic [ROW_W-1:0] row_inc;
    logic [ROW_W-1:0] row_e;
    logic [COL_W-1:0] col_e;
    logic             full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            filled_reg <= filled_next;
        end
    end

    assign row_inc = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
    assign full    = (col_reg >= COL_W'(COLS));
    assign row_e   = full ? row_inc : row_reg;
    assign col_e   = full ? '0 : col_reg;

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        filled_next = filled_reg;
        ops         = '0;
        ops.len_row   = row_reg;
        ops.len_val   = col_reg;
        ops.inval_row = row_inc;
        ops.text_addr = ADDR_W'(32'(row_e) * COLS + 32'(col_e));
        ops.text_data = ch;
        if (clr_en)
        begin
            row_next    = '0;
            col_next    = '0;
            filled_next = 1'b0;
        end
        else if (put_en)
        begin
            if (ch == CH_CR)
            begin
                row_next = row_reg;
            end
            else if (ch == CH_LF)
            begin
                ops.len_we   = 1'b1;
                ops.inval_en = 1'b1;
                row_next     = row_inc;
                col_next     = '0;
                if (row_inc == '0)
                begin
                    filled_next = 1'b1;
                end
            end
            else if (ch == CH_BS || ch == CH_DEL)
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - 1'b1;
                end
            end
            else if (ch < CH_SPACE)
            begin
                row_next = row_reg;
            end
            else
            begin
                if (full)
                begin
                    ops.len_we   = 1'b1;
                    ops.inval_en = 1'b1;
                    if (row_inc == '0)
                    begin
                        filled_next = 1'b1;
                    end
                end
                ops.text_we = 1'b1;
                row_next    = row_e;
                col_next    = col_e + 1'b1;
            end
        end
    end

    assign cur.row    = row_reg;
    assign cur.col    = col_reg;
    assign cur.filled = filled_reg;

endmodule
